// ===== design/esft_pkg.sv =====
// Shared types and constants for the epoch-seconds to FAT timestamp converter.
package esft_pkg;

   localparam int unsigned SEC_WIDTH = 32;
   localparam int unsigned MIN_WIDTH = 27;
   localparam int unsigned HRS_WIDTH = 21;
   localparam int unsigned DAY_WIDTH = 16;
   localparam int unsigned CYC_WIDTH = 6;
   localparam int unsigned YRS_WIDTH = 8;
   localparam int unsigned YDAY_WIDTH = 9;
   localparam int unsigned INCYC_WIDTH = 11;

   localparam int unsigned SEC_PER_MIN = 60;
   localparam int unsigned HOUR_PER_DAY = 24;
   localparam int unsigned DAYS_PER_YEAR = 365;
   localparam int unsigned DAYS_PER_CYCLE = 365 + 366 + 365 + 365;
   localparam int unsigned DAYS_1968_TO_1970 = 365 + 366;
   localparam int unsigned FIRST_MARCH_IN_LEAP = 31 + 29;
   localparam int unsigned BASE_YEAR = 1968;
   localparam int unsigned FAT_YEAR = 1980;

   localparam int unsigned SHIFT_SECS = 37;
   localparam int unsigned SHIFT_MINS = 32;
   localparam int unsigned SHIFT_HRS = 26;
   localparam int unsigned SHIFT_CYC = 27;
   localparam int unsigned SHIFT_YRS = 25;

   localparam longint unsigned RECIP_SECS =
      ((64'd1 << SHIFT_SECS) + SEC_PER_MIN - 1) / SEC_PER_MIN;
   localparam longint unsigned RECIP_MINS =
      ((64'd1 << SHIFT_MINS) + SEC_PER_MIN - 1) / SEC_PER_MIN;
   localparam longint unsigned RECIP_HRS =
      ((64'd1 << SHIFT_HRS) + HOUR_PER_DAY - 1) / HOUR_PER_DAY;
   localparam longint unsigned RECIP_CYC =
      ((64'd1 << SHIFT_CYC) + DAYS_PER_CYCLE - 1) / DAYS_PER_CYCLE;
   localparam longint unsigned RECIP_YRS =
      ((64'd1 << SHIFT_YRS) + DAYS_PER_YEAR - 1) / DAYS_PER_YEAR;

   localparam logic [YDAY_WIDTH-1:0] MONTH_START [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   typedef struct packed {
      logic [5:0] sec;
      logic [5:0] min;
      logic [4:0] hour;
   } hms_type;

endpackage

// ===== design/epoch_seconds_to_fat_timestamp.sv =====
// Pipelined converter from seconds since 1970 to calendar fields and a FAT date-time word.
//
//   Channel  Direction  Payload
//   req_     in         epoch_seconds (32 bits)
//   rsp_     out        fat_time, year, month, day_of_month, hour, minute, second
//
// One transfer enters per cycle unless a stall on the result channel holds the pipeline.
// The pipeline has nine register stages, with at most one reciprocal multiply in any stage.
// Reset clears the stage valid bits; data registers are not reset.
// A stall on the result channel holds every stage and is passed back on req_stall.
module epoch_seconds_to_fat_timestamp (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_fat_time,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day_of_month,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second
);
   import esft_pkg::*;

   logic                   advance;
   logic [8:0]             vld_ff, vld_in;

   logic [SEC_WIDTH-1:0]   secs1_ff, secs1_in;
   logic [MIN_WIDTH-1:0]   mins1_ff, mins1_in;

   logic [MIN_WIDTH-1:0]   mins2_ff, mins2_in;
   logic [5:0]             sec2_ff, sec2_in;
   logic [HRS_WIDTH-1:0]   hrs2_ff, hrs2_in;

   logic [5:0]             sec3_ff, sec3_in;
   logic [5:0]             min3_ff, min3_in;
   logic [HRS_WIDTH-1:0]   hrs3_ff, hrs3_in;
   logic [DAY_WIDTH-1:0]   days3_ff, days3_in;

   hms_type                hms4_ff, hms4_in, hms5_ff, hms6_ff, hms7_ff, hms8_ff;
   logic [DAY_WIDTH-1:0]   d68_4_ff, d68_4_in;
   logic [CYC_WIDTH-1:0]   q4_ff, q4_in;

   logic [DAY_WIDTH-1:0]   d68_5_ff;
   logic [CYC_WIDTH-1:0]   q5_ff;
   logic [INCYC_WIDTH-1:0] incyc5_ff, incyc5_in;

   logic [DAY_WIDTH-1:0]   nd6_ff, nd6_in;
   logic                   bump6_ff, bump6_in;

   logic [DAY_WIDTH-1:0]   nd7_ff;
   logic                   bump7_ff;
   logic [YRS_WIDTH-1:0]   yrs7_ff, yrs7_in;

   logic [YRS_WIDTH-1:0]   yrs8_ff;
   logic [YDAY_WIDTH-1:0]  yday8_ff, yday8_in;

   logic [31:0]            fat_ff, fat_in;
   logic [11:0]            year_ff, year_in;
   logic [3:0]             month_ff, month_in;
   logic [4:0]             mday_ff, mday_in;
   hms_type                hms9_ff;

   logic [63:0]            prod1, prod2, prod3, prod4, prod7;

   assign advance = !(vld_ff[8] && rsp_stall);
   assign req_stall = !advance;
   assign vld_in = {vld_ff[7:0], req_valid};

   always_comb begin
      logic [DAY_WIDTH-1:0]  d68;
      logic                  ge_march;
      logic                  leap;
      logic [YDAY_WIDTH-1:0] start;
      logic [YDAY_WIDTH-1:0] st;

      secs1_in = req_epoch_seconds;
      prod1 = 64'(req_epoch_seconds) * RECIP_SECS;
      mins1_in = prod1[SHIFT_SECS +: MIN_WIDTH];

      mins2_in = mins1_ff;
      sec2_in = 6'(secs1_ff - SEC_WIDTH'(mins1_ff) * SEC_WIDTH'(SEC_PER_MIN));
      prod2 = 64'(mins1_ff) * RECIP_MINS;
      hrs2_in = prod2[SHIFT_MINS +: HRS_WIDTH];

      sec3_in = sec2_ff;
      min3_in = 6'(mins2_ff - MIN_WIDTH'(hrs2_ff) * MIN_WIDTH'(SEC_PER_MIN));
      hrs3_in = hrs2_ff;
      prod3 = 64'(hrs2_ff) * RECIP_HRS;
      days3_in = prod3[SHIFT_HRS +: DAY_WIDTH];

      hms4_in.sec = sec3_ff;
      hms4_in.min = min3_ff;
      hms4_in.hour = 5'(hrs3_ff - HRS_WIDTH'(days3_ff) * HRS_WIDTH'(HOUR_PER_DAY));
      d68 = days3_ff + DAY_WIDTH'(DAYS_1968_TO_1970);
      d68_4_in = d68;
      prod4 = 64'(d68) * RECIP_CYC;
      q4_in = prod4[SHIFT_CYC +: CYC_WIDTH];

      incyc5_in = INCYC_WIDTH'(d68_4_ff - DAY_WIDTH'(q4_ff) * DAY_WIDTH'(DAYS_PER_CYCLE));

      ge_march = incyc5_ff >= INCYC_WIDTH'(FIRST_MARCH_IN_LEAP);
      nd6_in = d68_5_ff - DAY_WIDTH'(q5_ff) - DAY_WIDTH'(ge_march);
      bump6_in = ge_march && (incyc5_ff <= INCYC_WIDTH'(DAYS_PER_YEAR));

      prod7 = 64'(nd6_ff) * RECIP_YRS;
      yrs7_in = prod7[SHIFT_YRS +: YRS_WIDTH];

      yday8_in = YDAY_WIDTH'(nd7_ff - DAY_WIDTH'(yrs7_ff) * DAY_WIDTH'(DAYS_PER_YEAR))
                 + YDAY_WIDTH'(bump7_ff);

      leap = (yrs8_ff[1:0] == 2'b00);
      month_in = 4'd1;
      start = '0;
      for (int i = 0; i < 12; i++) begin
         st = MONTH_START[i] + YDAY_WIDTH'((i >= 2) && leap);
         if (yday8_ff >= st) begin
            month_in = 4'(i + 1);
            start = st;
         end
      end
      mday_in = 5'(yday8_ff - start + YDAY_WIDTH'(1));
      year_in = 12'(BASE_YEAR) + 12'(yrs8_ff);
      fat_in = {7'(year_in - 12'(FAT_YEAR)), month_in, mday_in, hms8_ff.hour,
                hms8_ff.min, hms8_ff.sec[5:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         secs1_ff <= secs1_in;
         mins1_ff <= mins1_in;

         mins2_ff <= mins2_in;
         sec2_ff <= sec2_in;
         hrs2_ff <= hrs2_in;

         sec3_ff <= sec3_in;
         min3_ff <= min3_in;
         hrs3_ff <= hrs3_in;
         days3_ff <= days3_in;

         hms4_ff <= hms4_in;
         d68_4_ff <= d68_4_in;
         q4_ff <= q4_in;

         hms5_ff <= hms4_ff;
         d68_5_ff <= d68_4_ff;
         q5_ff <= q4_ff;
         incyc5_ff <= incyc5_in;

         hms6_ff <= hms5_ff;
         nd6_ff <= nd6_in;
         bump6_ff <= bump6_in;

         hms7_ff <= hms6_ff;
         nd7_ff <= nd6_ff;
         bump7_ff <= bump6_ff;
         yrs7_ff <= yrs7_in;

         hms8_ff <= hms7_ff;
         yrs8_ff <= yrs7_ff;
         yday8_ff <= yday8_in;

         hms9_ff <= hms8_ff;
         fat_ff <= fat_in;
         year_ff <= year_in;
         month_ff <= month_in;
         mday_ff <= mday_in;
      end
   end

   assign rsp_valid = vld_ff[8];
   assign rsp_fat_time = fat_ff;
   assign rsp_year = year_ff;
   assign rsp_month = month_ff;
   assign rsp_day_of_month = mday_ff;
   assign rsp_hour = hms9_ff.hour;
   assign rsp_minute = hms9_ff.min;
   assign rsp_second = hms9_ff.sec;

endmodule

// ===== tb/tb_epoch_seconds_to_fat_timestamp.sv =====
// Self-checking testbench for the epoch-seconds to FAT timestamp pipeline.
`timescale 1ns / 1ps

module tb_epoch_seconds_to_fat_timestamp;
   import esft_pkg::*;

   localparam int unsigned RESET_CYCLES = 2;
   localparam int unsigned ITEMS_PER_PHASE = 206;
   localparam int unsigned HOLD_CYCLES = 150;
   localparam int unsigned DRAIN_CYCLES = 30;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned MAX_REPORTS = 10;
   localparam int unsigned SECS_PER_DAY = 86400;

   typedef struct packed {
      logic [31:0] fat_time;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } stamp_type;

   class stamp_scoreboard;
      stamp_type pending_stamps[$];
      int unsigned mismatches;

      function stamp_type predict_stamp(logic [31:0] secs);
         int unsigned month_first[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
         int unsigned total_min, total_hr, days, sec, min, hour;
         int unsigned d68, cyc_pos, leap_days, years_since, yday, year_val;
         int unsigned mon, first, mday;
         bit is_leap;
         stamp_type s;
         total_min = secs / SEC_PER_MIN;
         sec = secs - total_min * SEC_PER_MIN;
         total_hr = total_min / SEC_PER_MIN;
         min = total_min - total_hr * SEC_PER_MIN;
         days = total_hr / HOUR_PER_DAY;
         hour = total_hr - days * HOUR_PER_DAY;
         // Days are counted from 1968, so every four-year cycle opens with a leap year.
         d68 = days + DAYS_1968_TO_1970;
         cyc_pos = d68 % DAYS_PER_CYCLE;
         leap_days = d68 / DAYS_PER_CYCLE + ((cyc_pos >= FIRST_MARCH_IN_LEAP) ? 1 : 0);
         years_since = (d68 - leap_days) / DAYS_PER_YEAR;
         yday = d68 - years_since * DAYS_PER_YEAR - leap_days;
         if (cyc_pos <= DAYS_PER_YEAR && cyc_pos >= FIRST_MARCH_IN_LEAP) begin
            yday++;
         end
         year_val = years_since + BASE_YEAR;
         is_leap = (year_val % 4) == 0;
         mon = 1;
         first = 0;
         for (int m = 2; m <= 12; m++) begin
            if (yday >= month_first[m-1] + ((m > 2 && is_leap) ? 1 : 0)) begin
               mon = m;
               first = month_first[m-1] + ((m > 2 && is_leap) ? 1 : 0);
            end
         end
         mday = yday - first + 1;
         s.fat_time = {7'(year_val - FAT_YEAR), 4'(mon), 5'(mday), 5'(hour), 6'(min),
                       5'(sec >> 1)};
         s.year = 12'(year_val);
         s.month = 4'(mon);
         s.day_of_month = 5'(mday);
         s.hour = 5'(hour);
         s.minute = 6'(min);
         s.second = 6'(sec);
         return s;
      endfunction

      function void note_request(logic [31:0] secs);
         pending_stamps.push_back(predict_stamp(secs));
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("mismatch in %s: expected %0d (0x%h), got %0d (0x%h)",
                        name, want, want, got, got);
            end
         end
      endfunction

      function void check_result(stamp_type got);
         stamp_type want;
         if (pending_stamps.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("unexpected result transfer: fat_time 0x%h", got.fat_time);
            end
         end else begin
            want = pending_stamps.pop_front();
            compare_field("fat_time", want.fat_time, got.fat_time);
            compare_field("year", want.year, got.year);
            compare_field("month", want.month, got.month);
            compare_field("day_of_month", want.day_of_month, got.day_of_month);
            compare_field("hour", want.hour, got.hour);
            compare_field("minute", want.minute, got.minute);
            compare_field("second", want.second, got.second);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_epoch_seconds;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_fat_time;
   logic [11:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day_of_month;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second;

   stamp_scoreboard sb = new();
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned hold_left = 0;
   bit hold_req = 1'b0;
   int unsigned quiet_cycles = 0;

   epoch_seconds_to_fat_timestamp dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_epoch_seconds(req_epoch_seconds),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_fat_time(rsp_fat_time),
      .rsp_year(rsp_year),
      .rsp_month(rsp_month),
      .rsp_day_of_month(rsp_day_of_month),
      .rsp_hour(rsp_hour),
      .rsp_minute(rsp_minute),
      .rsp_second(rsp_second)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (hold_req) begin
         hold_req = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_request(req_epoch_seconds);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_result({rsp_fat_time, rsp_year, rsp_month, rsp_day_of_month, rsp_hour,
                             rsp_minute, rsp_second});
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_epoch_seconds_to_fat_timestamp NOT OK");
            $finish;
         end
      end
   end

   task automatic send_epoch(input logic [31:0] secs);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_epoch_seconds <= secs;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [31:0] random_epoch();
      int unsigned yr, days_to_year;
      int unsigned near_edge[5] = '{58, 59, 60, 364, 365};
      int unsigned day_edge[4] = '{0, 1, 86398, 86399};
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(49709) * SECS_PER_DAY + day_edge[$urandom_range(3)];
         2: begin
            // Land on the days around the end of February and the end of the year.
            yr = $urandom_range(2105, 1970);
            days_to_year = (yr - 1970) * 365 + (yr - 1969) / 4;
            return (days_to_year + near_edge[$urandom_range(4)]) * SECS_PER_DAY
                   + $urandom_range(SECS_PER_DAY - 1);
         end
         default: return $urandom_range(400000000);
      endcase
   endfunction

   task automatic send_random(input int unsigned count);
      repeat (count) send_epoch(random_epoch());
   endtask

   logic [31:0] directed_epochs[] = '{
      32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd86399, 32'd86400,
      32'd68169600, 32'd68256000, 32'd94607999, 32'd94608000,
      32'd315532799, 32'd315532800, 32'd951782400,
      32'd4107456000, 32'd4107542400, 32'd4107628800,
      32'h7fffffff, 32'h80000000, 32'haaaaaaaa, 32'h55555555,
      32'hfffffffe, 32'hffffffff
   };

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_epoch_seconds = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_epochs[i]) send_epoch(directed_epochs[i]);

      send_idle_pct = 0;
      stall_pct = 0;
      send_random(ITEMS_PER_PHASE);
      send_idle_pct = 72;
      send_random(ITEMS_PER_PHASE);
      send_idle_pct = 0;
      stall_pct = 72;
      send_random(ITEMS_PER_PHASE);
      send_idle_pct = 35;
      stall_pct = 35;
      send_random(ITEMS_PER_PHASE);

      // The receiver holds off while the sender keeps offering, so the pipeline backs up.
      send_idle_pct = 0;
      stall_pct = 0;
      hold_req = 1'b1;
      send_random(ITEMS_PER_PHASE);

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_stamps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_stamps.size() == 0) begin
         $display("tb_epoch_seconds_to_fat_timestamp OK");
      end else begin
         $display("tb_epoch_seconds_to_fat_timestamp NOT OK");
      end
      $finish;
   end

endmodule
